>>> src/indexed_sequence_store_top_assert.svh
// Assertion macros shared by the indexed sequence store modules.
`ifndef INDEXED_SEQUENCE_STORE_TOP_ASSERT_SVH
`define INDEXED_SEQUENCE_STORE_TOP_ASSERT_SVH

// Checked at every rising edge outside reset.
`define ISQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define ISQ_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

>>> src/isq_pkg.sv
// Types and constants of the indexed sequence store.
`default_nettype none

package isq_pkg;

   localparam int CAPACITY    = 16;
   localparam int MODE_W      = 2;
   localparam int POS_W       = 5;
   localparam int DATA_W      = 32;
   localparam int COUNT_OUT_W = 5;
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CMP_W       = (POS_W > CNT_W) ? POS_W : CNT_W;

   typedef enum logic [MODE_W-1:0] {
      MODE_READ   = 2'd0,
      MODE_INSERT = 2'd1,
      MODE_REMOVE = 2'd2
   } mode_type;

   // Shift command broadcast to every cell of the chain.
   typedef struct packed {
      logic             shift_up;
      logic             shift_down;
      logic [CMP_W-1:0] pos;
   } cell_ctl_type;

   // Outcome of the request being accepted.
   typedef struct packed {
      logic             ok;
      logic             returns_value;
      logic [CNT_W-1:0] count;
   } req_status_type;

endpackage

`default_nettype wire

>>> src/indexed_sequence_store_top.sv
// Indexed sequence store: a chain of value cells with read, insert and remove.
//
// Usage: a request transaction on req_* carries a mode (read, insert, remove),
// a zero-based position and, for insert, a value. Every request produces one
// response transaction on rsp_* with the value read or removed (0 for an
// insert or a failed request), an ok flag and the length after the request.
// Out-of-range positions, inserts into a full store and the unused mode give
// ok low and leave the contents unchanged.
// rsp_valid rises in the cycle after acceptance. A request is taken in
// every cycle: all cells shift or hold in parallel at the same edge, and the
// read is a single selection across the cells, so throughput is one request
// per cycle while the receiver keeps up.
// A pending response sits in the output register; req_ready drops only while
// that register is full and rsp_ready is low, so a stalled receiver holds the
// sender back without losing a response.
// Reset (synchronous, active high) empties the store and clears any pending
// response. The cell contents themselves are not cleared.
`default_nettype none

module indexed_sequence_store_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [isq_pkg::MODE_W-1:0]        req_mode,
   input  wire logic [isq_pkg::POS_W-1:0]         req_position,
   input  wire logic signed [isq_pkg::DATA_W-1:0] req_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [isq_pkg::DATA_W-1:0]      rsp_read_value,
   output logic                                   rsp_ok,
   output logic [isq_pkg::COUNT_OUT_W-1:0]        rsp_count
);
   import isq_pkg::*;

   logic                     accept;
   cell_ctl_type             ctl;
   req_status_type           status;
   logic signed [DATA_W-1:0] cell_value [CAPACITY];
   logic signed [DATA_W-1:0] read_data;

   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic signed [DATA_W-1:0]  rsp_value_ff;
   logic                      rsp_ok_ff;
   logic [COUNT_OUT_W-1:0]    rsp_count_ff;
   logic                      rsp_stall;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   isq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .mode     (req_mode),
      .position (req_position),
      .ctl      (ctl),
      .status   (status)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_value;
      logic signed [DATA_W-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_inner_left
         assign left_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_inner_right
         assign right_value = cell_value[i+1];
      end

      isq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .cell_index  (CMP_W'(i)),
         .new_value   (req_value),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_value[i])
      );
   end

   // A failed request may select a wrapped index; its data is discarded.
   assign read_data = cell_value[ctl.pos[IDX_W-1:0]];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_value_ff <= status.returns_value ? read_data : '0;
         rsp_ok_ff    <= status.ok;
         rsp_count_ff <= COUNT_OUT_W'(status.count);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_stall      = rsp_valid_ff && !rsp_ready;

`include "indexed_sequence_store_top_assert.svh"

   `ISQ_ASSERT(accept_gives_response, accept |=> rsp_valid, "accepted request without a response")
   `ISQ_ASSERT(failed_zero, (rsp_valid && !rsp_ok) |-> (rsp_value_ff == '0), "data on failure")
   `ISQ_ASSERT(rsp_holds, rsp_stall |=> rsp_valid && $stable(rsp_value_ff), "response lost")
   `ISQ_ASSERT_ALWAYS(reset_clears_rsp, reset |=> !rsp_valid, "response left after reset")

endmodule

`default_nettype wire

>>> src/isq_cell.sv
// One storage cell of the sequence: holds, loads or takes a neighbor's value.
`default_nettype none

module isq_cell (
   input  wire logic                              clock,
   input  wire isq_pkg::cell_ctl_type             ctl,
   input  wire logic [isq_pkg::CMP_W-1:0]         cell_index,
   input  wire logic signed [isq_pkg::DATA_W-1:0] new_value,
   input  wire logic signed [isq_pkg::DATA_W-1:0] left_value,
   input  wire logic signed [isq_pkg::DATA_W-1:0] right_value,
   output logic signed [isq_pkg::DATA_W-1:0]      value
);
   import isq_pkg::*;

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      priority if (ctl.shift_up && cell_index == ctl.pos) begin
         value_in = new_value;
      end else if (ctl.shift_up && cell_index > ctl.pos) begin
         value_in = left_value;
      end else if (ctl.shift_down && cell_index >= ctl.pos) begin
         value_in = right_value;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

>>> src/isq_ctrl.sv
// Request decode, range checks and the length counter.
`default_nettype none

module isq_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic [isq_pkg::MODE_W-1:0]  mode,
   input  wire logic [isq_pkg::POS_W-1:0]   position,
   output isq_pkg::cell_ctl_type            ctl,
   output isq_pkg::req_status_type          status
);
   import isq_pkg::*;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic             ok;
   logic             is_insert;
   logic             is_remove;

   assign pos_ext = CMP_W'(position);
   assign cnt_ext = CMP_W'(count_ff);

   always_comb begin
      ok        = 1'b0;
      is_insert = 1'b0;
      is_remove = 1'b0;
      unique case (mode)
         MODE_READ: begin
            ok = pos_ext < cnt_ext;
         end
         MODE_INSERT: begin
            is_insert = 1'b1;
            ok = (pos_ext <= cnt_ext) && (cnt_ext < CMP_W'(CAPACITY));
         end
         MODE_REMOVE: begin
            is_remove = 1'b1;
            ok = pos_ext < cnt_ext;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   assign ctl.shift_up   = accept && ok && is_insert;
   assign ctl.shift_down = accept && ok && is_remove;
   assign ctl.pos        = pos_ext;

   always_comb begin
      count_in = count_ff;
      priority if (ctl.shift_up) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.shift_down) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign status.ok            = ok;
   assign status.returns_value = ok && !is_insert;
   assign status.count         = count_in;

`include "indexed_sequence_store_top_assert.svh"

   `ISQ_ASSERT(count_in_range, count_ff <= CNT_W'(CAPACITY), "length count beyond capacity")
   `ISQ_ASSERT(one_shift_kind, !(ctl.shift_up && ctl.shift_down), "insert and remove at once")
   `ISQ_ASSERT(count_holds, !(ctl.shift_up || ctl.shift_down) |=> $stable(count_ff), "count moved")

endmodule

`default_nettype wire

>>> test/isq_checker.sv
// Response checker for the indexed sequence store: predicts every response and compares it.

module isq_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_ready,
   input  wire logic [isq_pkg::MODE_W-1:0]        req_mode,
   input  wire logic [isq_pkg::POS_W-1:0]         req_position,
   input  wire logic signed [isq_pkg::DATA_W-1:0] req_value,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   input  wire logic signed [isq_pkg::DATA_W-1:0] rsp_read_value,
   input  wire logic                              rsp_ok,
   input  wire logic [isq_pkg::COUNT_OUT_W-1:0]   rsp_count,
   output int                                     errors,
   output int                                     pending
);
   import isq_pkg::*;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      logic                     ok;
      logic [COUNT_OUT_W-1:0]   count;
   } rsp_fields_type;

   logic signed [DATA_W-1:0] shadow_cells [CAPACITY];
   int unsigned              shadow_len;
   rsp_fields_type           awaited_rsp_q [$];
   int                       mismatches;

   initial begin
      errors     = 0;
      pending    = 0;
      mismatches = 0;
      shadow_len = 0;
   end

   // Applies one request to the shadow sequence and returns the response it must produce.
   function automatic rsp_fields_type apply_request(input logic [MODE_W-1:0] m,
                                                    input logic [POS_W-1:0] p,
                                                    input logic signed [DATA_W-1:0] v);
      rsp_fields_type r;
      int unsigned    at;
      r.value = '0;
      r.ok    = 1'b0;
      at      = 32'(p);
      case (m)
         MODE_READ: begin
            if (at < shadow_len) begin
               r.value = shadow_cells[at];
               r.ok    = 1'b1;
            end
         end
         MODE_INSERT: begin
            if (at <= shadow_len && shadow_len < CAPACITY) begin
               for (int unsigned i = shadow_len; i > at; i--)
                  shadow_cells[i] = shadow_cells[i-1];
               shadow_cells[at] = v;
               shadow_len++;
               r.ok = 1'b1;
            end
         end
         MODE_REMOVE: begin
            if (at < shadow_len) begin
               r.value = shadow_cells[at];
               for (int unsigned i = at; i + 1 < shadow_len; i++)
                  shadow_cells[i] = shadow_cells[i+1];
               shadow_len--;
               r.ok = 1'b1;
            end
         end
         default: ;
      endcase
      r.count = shadow_len[COUNT_OUT_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_fields_type want;
      if (reset) begin
         shadow_len = 0;
         awaited_rsp_q.delete();
      end else begin
         // A response accepted at this edge belongs to an earlier request, so it is
         // matched before the request of this edge is queued.
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("MISMATCH: unexpected response: value %0d ok %0b count %0d",
                           rsp_read_value, rsp_ok, rsp_count);
            end else begin
               want = awaited_rsp_q.pop_front();
               if (rsp_read_value !== want.value || rsp_ok !== want.ok ||
                   rsp_count !== want.count) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"MISMATCH: expected value %0d ok %0b count %0d,",
                               " got value %0d ok %0b count %0d"},
                              want.value, want.ok, want.count,
                              rsp_read_value, rsp_ok, rsp_count);
               end
            end
         end
         if (req_valid && req_ready)
            awaited_rsp_q.push_back(apply_request(req_mode, req_position, req_value));
      end
      errors  <= mismatches;
      pending <= awaited_rsp_q.size();
   end

endmodule

>>> test/indexed_sequence_store_top_tb.sv
// Testbench top for the indexed sequence store: clock, reset, request stimulus and verdict.

module indexed_sequence_store_top_tb;
   import isq_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;
   localparam int                CYCLE_LIMIT  = 200_000;
   localparam int                RANDOM_ITEMS = 1600;

   logic                     clock;
   logic                     reset        = 1'b1;
   logic                     req_valid    = 1'b0;
   logic [MODE_W-1:0]        req_mode     = MODE_READ;
   logic [POS_W-1:0]         req_position = '0;
   logic signed [DATA_W-1:0] req_value    = '0;
   logic                     rsp_ready    = 1'b0;
   logic                     req_ready;
   logic                     rsp_valid;
   logic signed [DATA_W-1:0] rsp_read_value;
   logic                     rsp_ok;
   logic [COUNT_OUT_W-1:0]   rsp_count;

   int mismatch_total;
   int awaiting;
   bit no_stall      = 1'b0;
   int cycle_count   = 0;
   int length_hint   = 0;
   int full_inserts  = 0;
   int sent_per_mode [4];

   indexed_sequence_store_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_value (rsp_read_value),
      .rsp_ok         (rsp_ok),
      .rsp_count      (rsp_count)
   );

   isq_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_value (rsp_read_value),
      .rsp_ok         (rsp_ok),
      .rsp_count      (rsp_count),
      .errors         (mismatch_total),
      .pending        (awaiting)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= no_stall || ($urandom_range(0, 99) >= 15);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles.", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return -32'sd1;
         3:       return '0;
         default: return $urandom;
      endcase
   endfunction

   // Presents one request transaction, waits for it to be taken, then idles at random.
   task automatic issue(input logic [MODE_W-1:0] m, input logic [POS_W-1:0] p,
                        input logic signed [DATA_W-1:0] v);
      int gap;
      req_valid    <= 1'b1;
      req_mode     <= m;
      req_position <= p;
      req_value    <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_per_mode[m]++;
      // The sequence length follows from the requests alone; it steers positions.
      if (m == MODE_INSERT) begin
         if (length_hint == CAPACITY) full_inserts++;
         if (p <= length_hint && length_hint < CAPACITY) length_hint++;
      end else if (m == MODE_REMOVE) begin
         if (p < length_hint) length_hint--;
      end
      gap = 0;
      if (!no_stall)
         while ($urandom_range(0, 99) < 15) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic random_item(input bit filling);
      int                roll;
      logic [MODE_W-1:0] m;
      logic [POS_W-1:0]  p;
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
         m = MODE_W'($urandom_range(0, 3));
         p = POS_W'($urandom_range(0, 31));
      end else begin
         roll = $urandom_range(0, 99);
         if (filling)
            m = (roll < 55) ? MODE_INSERT : (roll < 80) ? MODE_READ : MODE_REMOVE;
         else
            m = (roll < 55) ? MODE_REMOVE : (roll < 80) ? MODE_READ : MODE_INSERT;
         if (m == MODE_INSERT)
            p = POS_W'($urandom_range(0, length_hint));
         else
            p = (length_hint > 0) ? POS_W'($urandom_range(0, length_hint - 1)) : '0;
         // Now and then aim at or past the end of the sequence.
         if ($urandom_range(0, 99) < 8)
            p = POS_W'($urandom_range(length_hint, 31));
      end
      issue(m, p, pick_value());
   endtask

   initial begin
      bit filling;
      filling = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty store, ends and middle, out-of-range and the unused mode.
      issue(MODE_READ,   5'd0,  32'sd7);
      issue(MODE_REMOVE, 5'd0,  32'sd7);
      issue(MODE_INSERT, 5'd1,  32'sd11);
      issue(MODE_INSERT, 5'd0,  32'sh8000_0000);
      issue(MODE_INSERT, 5'd0,  32'sh7FFF_FFFF);
      issue(MODE_INSERT, 5'd2,  -32'sd1);
      issue(MODE_INSERT, 5'd1,  32'sd0);
      issue(MODE_INSERT, 5'd31, 32'sd99);
      issue(MODE_READ,   5'd0,  32'sd0);
      issue(MODE_READ,   5'd3,  32'sd0);
      issue(MODE_READ,   5'd4,  32'sd0);
      issue(MODE_READ,   5'd31, 32'sd0);
      issue(MODE_UNUSED, 5'd0,  32'sd0);
      issue(MODE_UNUSED, 5'd31, -32'sd1);
      issue(MODE_REMOVE, 5'd1,  32'sd0);
      issue(MODE_REMOVE, 5'd2,  32'sd0);
      issue(MODE_REMOVE, 5'd0,  32'sd0);
      issue(MODE_REMOVE, 5'd5,  32'sd0);
      issue(MODE_READ,   5'd0,  32'sd0);
      issue(MODE_REMOVE, 5'd0,  32'sd0);
      issue(MODE_READ,   5'd0,  32'sd0);
      issue(MODE_REMOVE, 5'd31, 32'sd0);

      // Random part in alternating fill and drain phases, so the store runs full and empty.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         no_stall = (n >= 700 && n < 1000);
         if (filling && length_hint == CAPACITY && $urandom_range(0, 3) == 0)
            filling = 1'b0;
         else if (!filling && length_hint == 0 && $urandom_range(0, 3) == 0)
            filling = 1'b1;
         else if ($urandom_range(0, 199) == 0)
            filling = !filling;
         random_item(filling);
      end
      req_valid <= 1'b0;
      no_stall = 1'b0;

      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
      repeat (5) @(posedge clock);

      $display("Sent %0d reads, %0d inserts, %0d removes and %0d unused-mode requests,",
               sent_per_mode[MODE_READ], sent_per_mode[MODE_INSERT],
               sent_per_mode[MODE_REMOVE], sent_per_mode[MODE_UNUSED]);
      $display("with %0d inserts attempted on a full store and random stalls on both sides.",
               full_inserts);
      if (mismatch_total == 0 && awaiting == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+src
src/isq_pkg.sv
src/isq_cell.sv
src/isq_ctrl.sv
src/indexed_sequence_store_top.sv
test/isq_checker.sv
test/indexed_sequence_store_top_tb.sv
